FILE: rtl/stdist_pkg.sv
// Shared types, constants and command/status structs for the subnet topology distance block.
`timescale 1ns / 1ps

package stdist_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 64;
   localparam int MAX_LEVELS  = 4;
   localparam int ID_WIDTH    = 16;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int LVL_W       = 3;

   // Operation codes
   localparam logic [1:0] OP_WRITE   = 2'd0;
   localparam logic [1:0] OP_PAIR    = 2'd1;
   localparam logic [1:0] OP_NEAREST = 2'd2;

   // Register indexes
   localparam int         CSR_IDX_W       = 1;
   localparam int         CSR_DATA_W      = 7;
   localparam logic [0:0] CSR_LEVEL_COUNT = 1'd0;
   localparam logic [0:0] CSR_ENTRY_COUNT = 1'd1;

   // Running minimum idle value
   localparam logic [LVL_W-1:0] MIN_ALL_ONES = '1;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [5:0]  entry_index;
      logic [31:0] subnet_base;
      logic [5:0]  prefix_len;
      logic [2:0]  path_len;
      logic [15:0] path_level0;
      logic [15:0] path_level1;
      logic [15:0] path_level2;
      logic [15:0] path_level3;
      logic [31:0] addr_a;
      logic [31:0] addr_b;
      logic        last_in_set;
   } req_word_type;

   typedef struct packed {
      logic [2:0] topo_distance;
      logic       result_kind;
   } rsp_word_type;

   typedef logic [MAX_LEVELS-1:0][ID_WIDTH-1:0] path_type;

   // One table entry; base is stored pre-masked
   typedef struct packed {
      logic [31:0]      base_m;
      logic [31:0]      mask;
      logic [LVL_W-1:0] levels;
      path_type         path;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_CALC,
      ST_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic              start;
      logic              mem_wr;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              calc;
      logic              finish;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [CNT_W-1:0] scan_limit;
      logic             nearest;
      logic             last;
      logic             out_busy;
   } stat_type;

endpackage

FILE: rtl/stdist_ctrl.sv
// Sequencer for table writes, first-match scans and result hand-off.
`timescale 1ns / 1ps

module stdist_ctrl
   import stdist_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_opcode,
   output logic       req_ready,
   input  stat_type   stat,
   output cmd_type    cmd
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             accept;
   logic             is_query;
   logic             last_idx;
   logic             emit;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign is_query = (req_opcode == OP_PAIR) || (req_opcode == OP_NEAREST);
   assign last_idx = (idx_ff == (stat.scan_limit - CNT_W'(1)));
   assign emit     = !stat.nearest || stat.last;

   // Next state
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && is_query) begin
               idx_in   = '0;
               state_in = (stat.scan_limit == '0) ? ST_CALC : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_idx) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         ST_DRAIN: state_in = ST_CALC;
         ST_CALC:  state_in = ST_DONE;
         ST_DONE: begin
            if (!(emit && stat.out_busy)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.start  = accept && is_query;
            cmd.mem_wr = accept && (req_opcode == OP_WRITE);
         end
         ST_SCAN: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = idx_ff[ADDR_W-1:0];
         end
         ST_CALC: cmd.calc = 1'b1;
         ST_DONE: cmd.finish = !(emit && stat.out_busy);
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

FILE: rtl/stdist_dpath.sv
// Entry table, match compare, path compare, running minimum and result register.
`timescale 1ns / 1ps

module stdist_dpath
   import stdist_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  req_word_type          req_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  cmd_type               cmd,
   output stat_type              stat,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_data
);

   // Configuration registers
   logic [LVL_W-1:0] level_count_ff;
   logic [CNT_W-1:0] entry_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_count_ff <= LVL_W'(1);
         entry_count_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LEVEL_COUNT: level_count_ff <= csr_wdata[LVL_W-1:0];
            CSR_ENTRY_COUNT: entry_count_ff <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   logic [LVL_W-1:0] eff_levels;
   assign eff_levels = (level_count_ff > LVL_W'(MAX_LEVELS)) ? LVL_W'(MAX_LEVELS)
                                                             : level_count_ff;

   // Write word: mask from prefix length, saturated path length
   entry_type        wr_entry;
   logic [31:0]      wr_mask;
   logic [LVL_W-1:0] wr_levels;

   always_comb begin
      if (req_data.prefix_len >= 6'd32) begin
         wr_mask = '1;
      end else begin
         wr_mask = ~(32'hFFFF_FFFF >> req_data.prefix_len);
      end
      wr_levels = (req_data.path_len > LVL_W'(MAX_LEVELS)) ? LVL_W'(MAX_LEVELS)
                                                          : req_data.path_len;
      wr_entry.base_m  = req_data.subnet_base & wr_mask;
      wr_entry.mask    = wr_mask;
      wr_entry.levels  = wr_levels;
      wr_entry.path[0] = req_data.path_level0[ID_WIDTH-1:0];
      wr_entry.path[1] = req_data.path_level1[ID_WIDTH-1:0];
      wr_entry.path[2] = req_data.path_level2[ID_WIDTH-1:0];
      wr_entry.path[3] = req_data.path_level3[ID_WIDTH-1:0];
   end

   // Entry table, one write and one registered read a cycle
   entry_type mem [TABLE_DEPTH];
   entry_type rd_q_ff;

   always_ff @(posedge clock) begin
      if (cmd.mem_wr && ({26'd0, req_data.entry_index} < TABLE_DEPTH)) begin
         mem[req_data.entry_index[ADDR_W-1:0]] <= wr_entry;
      end
      if (cmd.rd_en) begin
         rd_q_ff <= mem[cmd.rd_addr];
      end
   end

   // Query latch
   logic [31:0] addr_a_ff, addr_b_ff;
   logic        nearest_ff, last_ff;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         addr_a_ff  <= req_data.addr_a;
         addr_b_ff  <= req_data.addr_b;
         nearest_ff <= (req_data.opcode == OP_NEAREST);
         last_ff    <= req_data.last_in_set;
      end
   end

   // First-match capture for both addresses
   logic             rd_vld_ff;
   logic             found_a_ff, found_b_ff;
   path_type         path_a_ff, path_b_ff;
   logic [LVL_W-1:0] len_a_ff, len_b_ff;
   logic             match_a, match_b;

   assign match_a = rd_vld_ff && !found_a_ff && ((addr_a_ff & rd_q_ff.mask) == rd_q_ff.base_m);
   assign match_b = rd_vld_ff && !found_b_ff && ((addr_b_ff & rd_q_ff.mask) == rd_q_ff.base_m);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         found_a_ff <= 1'b0;
         found_b_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.rd_en;
         if (cmd.start) begin
            found_a_ff <= 1'b0;
            found_b_ff <= 1'b0;
         end else begin
            if (match_a) found_a_ff <= 1'b1;
            if (match_b) found_b_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (match_a) begin
         path_a_ff <= rd_q_ff.path;
         len_a_ff  <= rd_q_ff.levels;
      end
      if (match_b) begin
         path_b_ff <= rd_q_ff.path;
         len_b_ff  <= rd_q_ff.levels;
      end
   end

   // Common prefix and distance
   path_type         pa, pb;
   logic [LVL_W-1:0] la, lb, lim, common;
   logic             run;
   logic [LVL_W-1:0] dist_in, dist_ff;

   always_comb begin
      pa     = found_a_ff ? path_a_ff : '0;
      pb     = found_b_ff ? path_b_ff : '0;
      la     = found_a_ff ? len_a_ff : eff_levels;
      lb     = found_b_ff ? len_b_ff : eff_levels;
      lim    = (la < lb) ? la : lb;
      common = '0;
      run    = 1'b1;
      for (int l = 0; l < MAX_LEVELS; l++) begin
         if (run && (LVL_W'(l) < lim) && (pa[l] == pb[l])) begin
            common = common + LVL_W'(1);
         end else begin
            run = 1'b0;
         end
      end
      dist_in = (eff_levels > common) ? (eff_levels - common) : '0;
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         dist_ff <= dist_in;
      end
   end

   // Running minimum and result register
   logic [LVL_W-1:0] run_min_ff, new_min;
   logic             emit;
   logic             rsp_valid_ff;
   rsp_word_type     rsp_data_ff;

   assign new_min = (dist_ff < run_min_ff) ? dist_ff : run_min_ff;
   assign emit    = !nearest_ff || last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_min_ff   <= MIN_ALL_ONES;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish && nearest_ff) begin
            run_min_ff <= last_ff ? MIN_ALL_ONES : new_min;
         end
         if (cmd.finish && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish && emit) begin
         rsp_data_ff.topo_distance <= nearest_ff ? new_min : dist_ff;
         rsp_data_ff.result_kind   <= nearest_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;
   assign stat.scan_limit = (entry_count_ff > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                                   : entry_count_ff;
   assign stat.nearest    = nearest_ff;
   assign stat.last       = last_ff;
   assign stat.out_busy   = rsp_valid_ff && !rsp_ready;

endmodule

FILE: rtl/subnet_topology_distance.sv
// Top level: subnet table lookup with topology path distance.
// A write word is taken in IDLE. A query holds req_ready low through SCAN, DRAIN, CALC and
// DONE, SCAN and DRAIN skipped when n is 0; DONE waits while a result to emit meets a stall.
// n is entry_count capped at table depth: one read port, one entry a cycle, both addresses.
// One query is in work at a time; a finished result waits in the output register.
// Synchronous active-high reset clears control, sets level_count 1, entry_count 0,
// and the running minimum to all ones; table contents are undefined until written.
`timescale 1ns / 1ps

module subnet_topology_distance
   import stdist_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_word_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   stdist_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_data.opcode),
      .req_ready  (req_ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   stdist_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/stdist_chk.sv
// Port-level checker for the subnet topology distance block, bound to the top level.
`timescale 1ns / 1ps

module stdist_chk
   import stdist_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input req_word_type          req_data,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input rsp_word_type          rsp_data
);

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // Reset leaves no result pending
   a_rsp_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A distance never exceeds the deepest path
   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.topo_distance <= 3'(MAX_LEVELS))
      else $error("distance out of range");

   // An accepted query makes the block busy for its scan
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      (req_data.opcode == OP_PAIR || req_data.opcode == OP_NEAREST) |=> !req_ready)
      else $error("ready after query accept");

endmodule

bind subnet_topology_distance stdist_chk u_chk (.*);
